// ----- rtl/min_heap_priority_queue_macros.svh -----
// Assertion helpers for the heap RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Clocked check, idle while reset is asserted.
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define MHPQ_NEVER(label, cond, msg) \
    `MHPQ_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/mhpq_pkg.sv -----
`default_nettype none

package mhpq_pkg;

    localparam int KEY_W             = 32;
    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PAYLOAD_WIDTH = 16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_START,
        S_FETCH,
        S_WALK,
        S_RESP
    } state_t;

    typedef struct packed
    {
        logic valid;
        logic is_del;
        logic shifting;
    } tok_ctrl_t;

    function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mhpq_ram.sv -----
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic      [WIDTH-1:0]                         rdata_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

// ----- rtl/mhpq_cell.sv -----
`default_nettype none

module mhpq_cell import mhpq_pkg::*; #(
    parameter int LEVEL         = 0,
    parameter int LEVELS        = 7,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tok_ctrl_t                       in_ctrl,
    input  wire logic [LEVELS-2:0]               in_pos,
    input  wire logic signed [KEY_W-1:0]         in_key,
    input  wire logic [PAYLOAD_WIDTH-1:0]        in_pay,
    input  wire logic [LEVELS-1:0]               in_num,
    input  wire logic [$clog2(LEVELS)-1:0]       in_dep,
    output tok_ctrl_t                            out_ctrl,
    output logic [LEVELS-2:0]                    out_pos,
    output logic signed [KEY_W-1:0]              out_key,
    output logic [PAYLOAD_WIDTH-1:0]             out_pay,
    output logic [LEVELS-1:0]                    out_num,
    output logic [$clog2(LEVELS)-1:0]            out_dep,
    input  wire logic                            peek_en,
    input  wire logic [LEVELS-2:0]               peek_pos,
    output logic signed [KEY_W-1:0]              peek_key,
    output logic [PAYLOAD_WIDTH-1:0]             peek_pay,
    input  wire logic                            uw_in_en,
    input  wire logic [LEVELS-2:0]               uw_in_pos,
    input  wire logic signed [KEY_W-1:0]         uw_in_key,
    input  wire logic [PAYLOAD_WIDTH-1:0]        uw_in_pay,
    output logic                                 uw_out_en,
    output logic [LEVELS-2:0]                    uw_out_pos,
    output logic signed [KEY_W-1:0]              uw_out_key,
    output logic [PAYLOAD_WIDTH-1:0]             uw_out_pay,
    output logic                                 done
);

    localparam int AW        = (LEVEL > 0) ? LEVEL : 1;
    localparam int POS_W     = LEVELS - 1;
    localparam int CNT_W     = LEVELS;
    localparam int DEP_W     = $clog2(LEVELS);
    localparam int IDX_W     = LEVELS + 2;
    localparam int ENT_W     = KEY_W + PAYLOAD_WIDTH;
    localparam int BASE      = (1 << LEVEL) - 1;
    localparam int NEXT_BASE = (1 << (LEVEL + 1)) - 1;

    tok_ctrl_t                  ctrl_reg;
    logic [POS_W-1:0]           pos_reg;
    logic signed [KEY_W-1:0]    key_reg;
    logic [PAYLOAD_WIDTH-1:0]   pay_reg;
    logic [CNT_W-1:0]           num_reg;
    logic [DEP_W-1:0]           dep_reg;

    logic [AW-1:0]              raddr_a;
    logic [AW-1:0]              raddr_b;
    logic [ENT_W-1:0]           rd_a;
    logic [ENT_W-1:0]           rd_b;
    logic signed [KEY_W-1:0]    a_key;
    logic signed [KEY_W-1:0]    b_key;
    logic [PAYLOAD_WIDTH-1:0]   a_pay;
    logic [PAYLOAD_WIDTH-1:0]   b_pay;

    logic                       own_we;
    logic [AW-1:0]              own_addr;
    logic [ENT_W-1:0]           own_data;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ENT_W-1:0]           ram_wdata;

    logic [IDX_W-1:0]           left_idx;
    logic [IDX_W-1:0]           right_idx;
    logic [IDX_W-1:0]           grand_idx;
    logic                       l_ok;
    logic                       r_ok;
    logic                       sel_l;
    logic                       sel_r;
    logic signed [KEY_W-1:0]    best_key;
    logic [AW-1:0]              child;
    logic [DEP_W-1:0]           bit_idx;
    logic                       path_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctrl.valid)
        begin
            pos_reg <= in_pos;
            key_reg <= in_key;
            pay_reg <= in_pay;
            num_reg <= in_num;
            dep_reg <= in_dep;
        end
    end

    always_comb
    begin
        if (peek_en)
        begin
            raddr_a = (LEVEL == 0) ? AW'(0) : peek_pos[AW-1:0];
        end
        else if (in_ctrl.is_del)
        begin
            raddr_a = AW'({in_pos, 1'b0});
        end
        else
        begin
            raddr_a = in_pos[AW-1:0];
        end
        raddr_b = AW'({in_pos, 1'b1});
    end

    mhpq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    assign a_key    = rd_a[KEY_W-1:0];
    assign a_pay    = rd_a[ENT_W-1:KEY_W];
    assign b_key    = rd_b[KEY_W-1:0];
    assign b_pay    = rd_b[ENT_W-1:KEY_W];
    assign peek_key = a_key;
    assign peek_pay = a_pay;

    assign left_idx  = IDX_W'(BASE) + IDX_W'({pos_reg, 1'b0});
    assign right_idx = left_idx + IDX_W'(1);
    assign l_ok      = left_idx < IDX_W'(num_reg);
    assign r_ok      = right_idx < IDX_W'(num_reg);
    assign sel_l     = l_ok && key_less(a_key, key_reg);
    assign best_key  = sel_l ? a_key : key_reg;
    assign sel_r     = r_ok && key_less(b_key, best_key);
    assign child     = AW'({pos_reg, sel_r});
    assign grand_idx = IDX_W'(NEXT_BASE) + IDX_W'({child, 1'b0});
    assign bit_idx   = dep_reg - DEP_W'(LEVEL) - DEP_W'(1);
    assign path_bit  = num_reg[bit_idx];

    always_comb
    begin
        own_we     = 1'b0;
        own_addr   = pos_reg[AW-1:0];
        own_data   = {pay_reg, key_reg};
        out_ctrl   = '0;
        out_pos    = '0;
        out_key    = key_reg;
        out_pay    = pay_reg;
        out_num    = num_reg;
        out_dep    = dep_reg;
        uw_out_en  = 1'b0;
        uw_out_pos = pos_reg;
        uw_out_key = key_reg;
        uw_out_pay = pay_reg;
        done       = 1'b0;

        if (ctrl_reg.valid && !ctrl_reg.is_del)
        begin
            if (dep_reg == DEP_W'(LEVEL))
            begin
                own_we = 1'b1;
                done   = 1'b1;
            end
            else
            begin
                out_ctrl.valid  = 1'b1;
                out_ctrl.is_del = 1'b0;
                out_pos         = POS_W'({pos_reg[AW-1:0], path_bit});
                if (ctrl_reg.shifting || key_less(key_reg, a_key))
                begin
                    // take this slot, push the old entry one level down
                    own_we            = 1'b1;
                    out_key           = a_key;
                    out_pay           = a_pay;
                    out_ctrl.shifting = 1'b1;
                end
            end
        end
        else if (ctrl_reg.valid)
        begin
            uw_out_en = 1'b1;
            if (sel_l || sel_r)
            begin
                uw_out_key = sel_r ? b_key : a_key;
                uw_out_pay = sel_r ? b_pay : a_pay;
                if (grand_idx < IDX_W'(num_reg))
                begin
                    out_ctrl.valid  = 1'b1;
                    out_ctrl.is_del = 1'b1;
                    out_pos         = POS_W'(child);
                end
                else
                begin
                    own_we   = 1'b1;
                    own_addr = child;
                    done     = 1'b1;
                end
            end
            else
            begin
                done = 1'b1;
            end
        end
    end

    always_comb
    begin
        ram_we = own_we || uw_in_en;
        if (own_we)
        begin
            ram_waddr = own_addr;
            ram_wdata = own_data;
        end
        else
        begin
            ram_waddr = uw_in_pos[AW-1:0];
            ram_wdata = {uw_in_pay, uw_in_key};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/min_heap_priority_queue.sv -----
// Binary min-heap priority queue. Each input transfer is an insert (tuser 0)
// or a delete-minimum (tuser 1); each gives one output transfer with the
// removed entry (zero unless a delete succeeded), a status in tuser and the
// new occupancy. The heap is a chain of level cells, one per tree level, each
// owning the memory of its level; an operation walks the chain one level per
// cycle, the registered memory read of a level being issued as the operation
// is handed to it, so compare and write follow in the next cycle. An accepted
// insert passes the states START, WALK and RESP, the walk running from the
// root down to the level of the new slot; a delete passes START, FETCH, WALK
// and RESP, the walk visiting the levels below the root (at most one more
// than the levels the moved entry sinks). A delete that empties the heap
// skips WALK, and a refused operation goes from START straight to RESP. The
// result is presented in the same cycle as s_tready returns. One item is in
// work at a time; the next is taken while the previous result still waits at
// the output, and its own result then holds until the output is free. Entry
// memories are not cleared and need no clearing pass after reset.
`default_nettype none

`include "min_heap_priority_queue_macros.svh"

module min_heap_priority_queue import mhpq_pkg::*; #(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // key, payload
    input  wire logic [((KEY_W + PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_key, out_payload, occupancy
    output logic [((KEY_W + PAYLOAD_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [1:0]               m_tuser
);

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int CNT_W  = LEVELS;
    localparam int POS_W  = LEVELS - 1;
    localparam int DEP_W  = $clog2(LEVELS);
    localparam int OUT_DW = ((KEY_W + PAYLOAD_WIDTH + CNT_W + 7) / 8) * 8;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    op_t                      op_reg;
    logic signed [KEY_W-1:0]  ikey_reg;
    logic [PAYLOAD_WIDTH-1:0] ipay_reg;
    logic [DEP_W-1:0]         dep_reg;
    logic [DEP_W-1:0]         dep_next;
    logic signed [KEY_W-1:0]  res_key_reg;
    logic signed [KEY_W-1:0]  res_key_next;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg;
    logic [PAYLOAD_WIDTH-1:0] res_pay_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [OUT_DW-1:0]        m_data_reg;
    status_t                  m_user_reg;
    logic                     m_load;

    logic [CNT_W-1:0]         num_sel;
    logic [DEP_W-1:0]         num_dep;
    logic [POS_W-1:0]         peek_pos;
    logic                     peek_en;

    tok_ctrl_t                inj_ctrl;
    logic signed [KEY_W-1:0]  inj_key;
    logic [PAYLOAD_WIDTH-1:0] inj_pay;
    logic [CNT_W-1:0]         inj_num;
    logic [DEP_W-1:0]         inj_dep;

    tok_ctrl_t                cin_ctrl [LEVELS];
    logic [POS_W-1:0]         cin_pos  [LEVELS];
    logic signed [KEY_W-1:0]  cin_key  [LEVELS];
    logic [PAYLOAD_WIDTH-1:0] cin_pay  [LEVELS];
    logic [CNT_W-1:0]         cin_num  [LEVELS];
    logic [DEP_W-1:0]         cin_dep  [LEVELS];

    tok_ctrl_t                fwd_ctrl [1:LEVELS];
    logic [POS_W-1:0]         fwd_pos  [1:LEVELS];
    logic signed [KEY_W-1:0]  fwd_key  [1:LEVELS];
    logic [PAYLOAD_WIDTH-1:0] fwd_pay  [1:LEVELS];
    logic [CNT_W-1:0]         fwd_num  [1:LEVELS];
    logic [DEP_W-1:0]         fwd_dep  [1:LEVELS];

    logic                     uw_en    [LEVELS + 1];
    logic [POS_W-1:0]         uw_pos   [LEVELS + 1];
    logic signed [KEY_W-1:0]  uw_key   [LEVELS + 1];
    logic [PAYLOAD_WIDTH-1:0] uw_pay   [LEVELS + 1];

    logic signed [KEY_W-1:0]  peek_key [LEVELS];
    logic [PAYLOAD_WIDTH-1:0] peek_pay [LEVELS];
    logic [LEVELS-1:0]        done_vec;
    logic                     done_any;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign done_any = |done_vec;

    assign num_sel  = (op_reg == OP_INSERT) ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        num_dep = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (num_sel[i])
            begin
                num_dep = DEP_W'(i);
            end
        end
    end

    assign peek_pos = POS_W'(count_reg & ~(CNT_W'(1) << num_dep));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= op_t'(s_tuser);
            ikey_reg <= s_tdata[KEY_W-1:0];
            ipay_reg <= s_tdata[KEY_W+PAYLOAD_WIDTH-1:KEY_W];
        end
        dep_reg     <= dep_next;
        res_key_reg <= res_key_next;
        res_pay_reg <= res_pay_next;
        status_reg  <= status_next;
        if (m_load)
        begin
            m_data_reg <= OUT_DW'({count_reg, res_pay_reg, res_key_reg});
            m_user_reg <= status_reg;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dep_next     = dep_reg;
        res_key_next = res_key_reg;
        res_pay_next = res_pay_reg;
        status_next  = status_reg;
        peek_en      = 1'b0;
        m_load       = 1'b0;
        inj_ctrl     = '0;
        inj_key      = ikey_reg;
        inj_pay      = ipay_reg;
        inj_num      = num_sel;
        inj_dep      = num_dep;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_key_next = '0;
                res_pay_next = '0;
                status_next  = ST_OK;
                if (op_reg == OP_INSERT)
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        inj_ctrl.valid = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        state_next     = S_WALK;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        // read root and last entry in the same cycle
                        peek_en    = 1'b1;
                        dep_next   = num_dep;
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                res_key_next = peek_key[0];
                res_pay_next = peek_pay[0];
                if (count_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    inj_ctrl.valid  = 1'b1;
                    inj_ctrl.is_del = 1'b1;
                    inj_key         = peek_key[dep_reg];
                    inj_pay         = peek_pay[dep_reg];
                    inj_num         = count_reg;
                    inj_dep         = '0;
                    state_next      = S_WALK;
                end
            end
            S_WALK:
            begin
                if (done_any)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign uw_en[LEVELS]  = 1'b0;
    assign uw_pos[LEVELS] = '0;
    assign uw_key[LEVELS] = '0;
    assign uw_pay[LEVELS] = '0;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        if (g == 0)
        begin : g_root
            always_comb
            begin
                cin_ctrl[g]       = inj_ctrl;
                cin_ctrl[g].valid = inj_ctrl.valid && !inj_ctrl.is_del;
                cin_pos[g]        = '0;
                cin_key[g]        = inj_key;
                cin_pay[g]        = inj_pay;
                cin_num[g]        = inj_num;
                cin_dep[g]        = inj_dep;
            end
        end
        else if (g == 1)
        begin : g_first
            always_comb
            begin
                if (inj_ctrl.valid && inj_ctrl.is_del)
                begin
                    cin_ctrl[g] = inj_ctrl;
                    cin_pos[g]  = '0;
                    cin_key[g]  = inj_key;
                    cin_pay[g]  = inj_pay;
                    cin_num[g]  = inj_num;
                    cin_dep[g]  = inj_dep;
                end
                else
                begin
                    cin_ctrl[g] = fwd_ctrl[g];
                    cin_pos[g]  = fwd_pos[g];
                    cin_key[g]  = fwd_key[g];
                    cin_pay[g]  = fwd_pay[g];
                    cin_num[g]  = fwd_num[g];
                    cin_dep[g]  = fwd_dep[g];
                end
            end
        end
        else
        begin : g_inner
            assign cin_ctrl[g] = fwd_ctrl[g];
            assign cin_pos[g]  = fwd_pos[g];
            assign cin_key[g]  = fwd_key[g];
            assign cin_pay[g]  = fwd_pay[g];
            assign cin_num[g]  = fwd_num[g];
            assign cin_dep[g]  = fwd_dep[g];
        end

        mhpq_cell #(
            .LEVEL         (g),
            .LEVELS        (LEVELS),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_ctrl    (cin_ctrl[g]),
            .in_pos     (cin_pos[g]),
            .in_key     (cin_key[g]),
            .in_pay     (cin_pay[g]),
            .in_num     (cin_num[g]),
            .in_dep     (cin_dep[g]),
            .out_ctrl   (fwd_ctrl[g+1]),
            .out_pos    (fwd_pos[g+1]),
            .out_key    (fwd_key[g+1]),
            .out_pay    (fwd_pay[g+1]),
            .out_num    (fwd_num[g+1]),
            .out_dep    (fwd_dep[g+1]),
            .peek_en    (peek_en),
            .peek_pos   (peek_pos),
            .peek_key   (peek_key[g]),
            .peek_pay   (peek_pay[g]),
            .uw_in_en   (uw_en[g+1]),
            .uw_in_pos  (uw_pos[g+1]),
            .uw_in_key  (uw_key[g+1]),
            .uw_in_pay  (uw_pay[g+1]),
            .uw_out_en  (uw_en[g]),
            .uw_out_pos (uw_pos[g]),
            .uw_out_key (uw_key[g]),
            .uw_out_pay (uw_pay[g]),
            .done       (done_vec[g])
        );
    end

    `MHPQ_NEVER(a_no_bottom_exit, fwd_ctrl[LEVELS].valid, "operation left the deepest level")
    `MHPQ_NEVER(a_root_no_upwrite, uw_en[0], "root level issued an upward write")
    `MHPQ_NEVER(a_count_range, count_reg > CNT_W'(CAPACITY), "entry count above capacity")
    `MHPQ_ASSERT(a_one_done, $onehot0(done_vec), "several levels finished at once")
    `MHPQ_ASSERT(a_done_in_walk, done_any |-> state_reg == S_WALK, "level finished outside a walk")

endmodule

`default_nettype wire

// ----- bench/min_heap_priority_queue_test.sv -----
`default_nettype none

module min_heap_priority_queue_test import mhpq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP     = DEF_CAPACITY;
    localparam int PAY_W   = DEF_PAYLOAD_WIDTH;
    localparam int OCC_W   = $clog2(CAP + 1);
    localparam int S_W     = ((KEY_W + PAY_W + 7) / 8) * 8;
    localparam int M_W     = ((KEY_W + PAY_W + OCC_W + 7) / 8) * 8;
    localparam int LIMIT   = 500000;
    localparam int BLOCKS  = 16;
    localparam int BLOCK_N = 70;
    localparam int MAX_LOG = 40;

    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        status_t          st;
        logic [OCC_W-1:0] occ;
    } heap_res_t;

    typedef struct packed
    {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic             typed;
        heap_res_t        res;
    } row_t;

    localparam int N_ROWS = 25;
    localparam row_t STEPS [0:N_ROWS-1] = '{
        '{OP_DELETE, 32'h5a5a5a5a, 16'ha5a5, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 7'd0}},
        '{OP_INSERT, 32'h7fffffff, 16'hffff, 1'b1, '{32'h0, 16'h0, ST_OK, 7'd1}},
        '{OP_INSERT, 32'h80000000, 16'h0000, 1'b1, '{32'h0, 16'h0, ST_OK, 7'd2}},
        '{OP_DELETE, 32'hffffffff, 16'hffff, 1'b1,
          '{32'h80000000, 16'h0000, ST_OK, 7'd1}},
        '{OP_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{32'h7fffffff, 16'hffff, ST_OK, 7'd0}},
        '{OP_DELETE, 32'ha5a5a5a5, 16'h5a5a, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 7'd0}},
        '{OP_INSERT, 32'h00000005, 16'h0001, 1'b0, '0},
        '{OP_INSERT, 32'h00000005, 16'h0002, 1'b0, '0},
        '{OP_INSERT, 32'h00000005, 16'h0003, 1'b0, '0},
        '{OP_INSERT, 32'hffffffff, 16'haaaa, 1'b0, '0},
        '{OP_INSERT, 32'h00000005, 16'h5555, 1'b0, '0},
        '{OP_INSERT, 32'h00000000, 16'h8001, 1'b0, '0},
        '{OP_INSERT, 32'h80000000, 16'h0f0f, 1'b0, '0},
        '{OP_INSERT, 32'h7fffffff, 16'hf0f0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 7'd0}},
        '{OP_INSERT, 32'hfffffff9, 16'h1234, 1'b0, '0},
        '{OP_DELETE, 32'h0, 16'h0, 1'b0, '0}
    };

    localparam int INS_BIAS [0:BLOCKS-1] = '{100, 0, 85, 15, 50, 92, 8, 60,
                                             40, 97, 3, 70, 30, 100, 0, 50};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic [1:0]       m_tuser;

    logic signed [KEY_W-1:0] heap_key [0:CAP-1];
    logic [PAY_W-1:0]        heap_pay [0:CAP-1];
    int                      heap_fill;

    heap_res_t pending_q [$];
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        stall_asks;
    int        stall_seen;
    int        stall_left;
    int        cycles;
    int        errors;
    int        n_ins;
    int        n_del;
    int        n_full;
    int        n_empty;
    int        peak_fill;

    min_heap_priority_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        errors++;
        if (errors <= MAX_LOG)
            $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic heap_res_t heap_step(input op_t op, input logic [KEY_W-1:0] key,
                                            input logic [PAY_W-1:0] pay);
        heap_res_t               r;
        int                      i;
        int                      parent;
        int                      node;
        int                      pick;
        logic signed [KEY_W-1:0] tk;
        logic [PAY_W-1:0]        tp;
        r = '0;
        r.st = ST_OK;
        if (op == OP_INSERT)
        begin
            n_ins++;
            if (heap_fill >= CAP)
            begin
                r.st = ST_FULL;
                n_full++;
            end
            else
            begin
                i = heap_fill;
                heap_fill++;
                while (i > 0)
                begin
                    parent = (i - 1) / 2;
                    if (!($signed(key) < heap_key[parent]))
                        break;
                    heap_key[i] = heap_key[parent];
                    heap_pay[i] = heap_pay[parent];
                    i = parent;
                end
                heap_key[i] = key;
                heap_pay[i] = pay;
            end
        end
        else
        begin
            n_del++;
            if (heap_fill == 0)
            begin
                r.st = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                r.key = heap_key[0];
                r.pay = heap_pay[0];
                heap_fill--;
                heap_key[0] = heap_key[heap_fill];
                heap_pay[0] = heap_pay[heap_fill];
                node = 0;
                forever
                begin
                    pick = node;
                    if (2 * node + 1 < heap_fill && heap_key[2 * node + 1] < heap_key[node])
                        pick = 2 * node + 1;
                    if (2 * node + 2 < heap_fill && heap_key[2 * node + 2] < heap_key[pick])
                        pick = 2 * node + 2;
                    if (pick == node)
                        break;
                    tk = heap_key[node];
                    tp = heap_pay[node];
                    heap_key[node] = heap_key[pick];
                    heap_pay[node] = heap_pay[pick];
                    heap_key[pick] = tk;
                    heap_pay[pick] = tp;
                    node = pick;
                end
            end
        end
        if (heap_fill > peak_fill)
            peak_fill = heap_fill;
        r.occ = OCC_W'(heap_fill);
        return r;
    endfunction

    task automatic offer(input op_t op, input logic [KEY_W-1:0] key,
                         input logic [PAY_W-1:0] pay, input logic typed,
                         input heap_res_t want);
        heap_res_t r;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_W'({pay, key});
        do
            @(posedge clk);
        while (!s_tready);
        r = heap_step(op, key, pay);
        pending_q.push_back(typed ? want : r);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom;
            1: return KEY_W'($signed($urandom_range(8)) - 4);
            2: return $urandom_range(1) ? 32'h80000000 + $urandom_range(3)
                                        : 32'h7fffffff - $urandom_range(3);
            default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_asks != stall_seen)
        begin
            stall_seen = stall_asks;
            stall_left = 400;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        heap_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected transfer, data", m_tdata[KEY_W-1:0], '0);
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key)
                    report_mismatch("out_key", m_tdata[KEY_W-1:0], want.key);
                if (m_tdata[KEY_W +: PAY_W] !== want.pay)
                    report_mismatch("out_payload", KEY_W'(m_tdata[KEY_W +: PAY_W]),
                                    KEY_W'(want.pay));
                if (m_tuser !== want.st)
                    report_mismatch("status", KEY_W'(m_tuser), KEY_W'(want.st));
                if (m_tdata[KEY_W + PAY_W +: OCC_W] !== want.occ)
                    report_mismatch("occupancy", KEY_W'(m_tdata[KEY_W + PAY_W +: OCC_W]),
                                    KEY_W'(want.occ));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d transfers outstanding",
                     cycles, pending_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        op_t op;
        heap_fill   = 0;
        errors      = 0;
        cycles      = 0;
        stall_asks  = 0;
        stall_seen  = 0;
        stall_left  = 0;
        n_ins       = 0;
        n_del       = 0;
        n_full      = 0;
        n_empty     = 0;
        peak_fill   = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 56;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_ROWS; n++)
            offer(STEPS[n].op, STEPS[n].key, STEPS[n].pay, STEPS[n].typed, STEPS[n].res);

        for (int b = 0; b < BLOCKS; b++)
        begin
            if (b == 6 || b == 12)
            begin
                drain();
                tx_idle_pct = (b == 6) ? 56 : 0;
                rx_idle_pct = (b == 6) ? 29 : 0;
            end
            if (b == 1)
                stall_asks++;
            for (int n = 0; n < BLOCK_N; n++)
            begin
                op = ($urandom_range(99) < INS_BIAS[b]) ? OP_INSERT : OP_DELETE;
                offer(op, pick_key(), PAY_W'($urandom), 1'b0, '0);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("%0d inserts (%0d refused full), %0d deletes (%0d refused empty)",
                 n_ins, n_full, n_del, n_empty);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_fill, CAP, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
